>>> sv/lmce_pkg.sv
// Package for the list-mode character escaper.
// Holds the byte codes, the run type and the reset value of the fold column.
// No dependencies.
`timescale 1ns / 1ps

package lmce_pkg;

  localparam int unsigned MAX_RUN = 6;
  localparam int unsigned RUN_LEN_W = $clog2(MAX_RUN + 1);
  localparam int unsigned RUN_IDX_W = $clog2(MAX_RUN);

  localparam logic [6:0] FOLD_COLUMN_RESET = 7'd66;

  localparam logic [7:0] CH_BS      = 8'h08;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_LOWER_B = 8'h62;
  localparam logic [7:0] CH_LOWER_N = 8'h6E;
  localparam logic [7:0] CH_LOWER_T = 8'h74;
  localparam logic [7:0] CH_DEL     = 8'h7F;

  // The bytes one character expands into, in emit order, and how many there are.
  typedef struct packed {
    logic [MAX_RUN-1:0][7:0] bytes;
    logic [RUN_LEN_W-1:0]    len;
  } run_t;

endpackage

>>> sv/lmce_in_reg.sv
// Input register of the list-mode character escaper.
// Holds one accepted character until the escape stage takes it; uses lmce_pkg.
`timescale 1ns / 1ps

module lmce_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_in,
  input  logic       in_list_mode,
  input  logic       take,
  output logic       held_vld,
  output logic [7:0] held_char,
  output logic       held_list
);
  import lmce_pkg::*;

  logic       vld_r, vld_nxt;
  logic [7:0] char_r;
  logic       list_r;
  logic       accept;

  // The register can refill in the same cycle that the escape stage empties it.
  assign in_stall = vld_r && !take;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (accept) begin
      vld_nxt = 1'b1;
    end else if (take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      char_r <= in_char_in;
      list_r <= in_list_mode;
    end
  end

  assign held_vld  = vld_r;
  assign held_char = char_r;
  assign held_list = list_r;

endmodule

>>> sv/lmce_escape.sv
// Escape stage of the list-mode character escaper.
// Expands one character into its run of bytes and keeps the column, the
// space flag and the fold column register; uses lmce_pkg.
`timescale 1ns / 1ps

module lmce_escape (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_wr_en,
  input  logic [6:0]    cfg_wr_data,
  input  logic [7:0]    char_in,
  input  logic          list_mode,
  input  logic          load,
  output lmce_pkg::run_t run
);
  import lmce_pkg::*;

  logic [6:0] fold_column_r;
  logic [7:0] column_r, column_nxt;
  logic       space_r, space_nxt;

  logic                 is_nl;
  logic                 do_fold;
  logic                 is_esc2;
  logic                 is_oct;
  logic [7:0]           col_base;
  logic [3:0][7:0]      body;
  logic [RUN_LEN_W-1:0] body_len;
  logic [7:0]           final_byte;

  assign is_nl   = (char_in == CH_NL);
  assign do_fold = list_mode && !is_nl && (column_r >= {1'b0, fold_column_r});
  assign is_esc2 = (char_in == CH_BS) || (char_in == CH_TAB) || (char_in == CH_BSLASH);
  assign is_oct  = (char_in < CH_SPACE) || (char_in >= CH_DEL);
  assign col_base = do_fold ? 8'd0 : column_r;

  // Body of the run, without the fold prefix.
  always_comb begin
    body       = '0;
    body_len   = RUN_LEN_W'(1);
    body[0]    = char_in;
    final_byte = char_in;
    column_nxt = column_r;
    if (list_mode && !is_nl) begin
      if (is_esc2) begin
        body[0]  = CH_BSLASH;
        body[1]  = (char_in == CH_BS)  ? CH_LOWER_B :
                   (char_in == CH_TAB) ? CH_LOWER_T : CH_BSLASH;
        body_len = RUN_LEN_W'(2);
        final_byte = body[1];
        column_nxt = col_base + 8'd2;
      end else if (is_oct) begin
        body[0]  = CH_BSLASH;
        body[1]  = {6'b001100, char_in[7:6]};
        body[2]  = {5'b00110, char_in[5:3]};
        body[3]  = {5'b00110, char_in[2:0]};
        body_len = RUN_LEN_W'(4);
        final_byte = body[3];
        column_nxt = col_base + 8'd4;
      end else begin
        column_nxt = col_base + 8'd1;
      end
    end else if (list_mode && space_r) begin
      // A newline after a space gets a visible marker first.
      body[0]  = CH_BSLASH;
      body[1]  = CH_LOWER_N;
      body[2]  = CH_NL;
      body_len = RUN_LEN_W'(3);
    end
    if (is_nl) begin
      column_nxt = 8'd0;
    end
    space_nxt = (final_byte == CH_SPACE);
  end

  // A fold puts backslash-newline in front of the body.
  always_comb begin
    run.bytes[0] = do_fold ? CH_BSLASH : body[0];
    run.bytes[1] = do_fold ? CH_NL     : body[1];
    run.bytes[2] = do_fold ? body[0]   : body[2];
    run.bytes[3] = do_fold ? body[1]   : body[3];
    run.bytes[4] = body[2];
    run.bytes[5] = body[3];
    run.len      = do_fold ? body_len + RUN_LEN_W'(2) : body_len;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fold_column_r <= FOLD_COLUMN_RESET;
      column_r      <= 8'd0;
      space_r       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        fold_column_r <= cfg_wr_data;
      end
      if (load) begin
        column_r <= column_nxt;
        space_r  <= space_nxt;
      end
    end
  end

endmodule

>>> sv/lmce_run_buf.sv
// Output run register of the list-mode character escaper.
// Holds one expanded run and sends it out a byte per transfer; uses lmce_pkg.
`timescale 1ns / 1ps

module lmce_run_buf (
  input  logic           clk,
  input  logic           rst_n,
  input  lmce_pkg::run_t run,
  input  logic           src_vld,
  output logic           load,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_byte,
  output logic           out_last_of_run
);
  import lmce_pkg::*;

  logic [MAX_RUN-1:0][7:0] bytes_r;
  logic [RUN_LEN_W-1:0]    len_r, len_nxt;
  logic [RUN_IDX_W-1:0]    idx_r, idx_nxt;
  logic                    xfer;
  logic                    last;

  assign out_valid       = (len_r != '0);
  assign last            = (RUN_LEN_W'(idx_r) == len_r - RUN_LEN_W'(1));
  assign xfer            = out_valid && !out_stall;
  assign load            = src_vld && (!out_valid || (xfer && last));
  assign out_byte        = bytes_r[idx_r];
  assign out_last_of_run = last;

  always_comb begin
    len_nxt = len_r;
    idx_nxt = idx_r;
    if (load) begin
      len_nxt = run.len;
      idx_nxt = '0;
    end else if (xfer && last) begin
      len_nxt = '0;
      idx_nxt = '0;
    end else if (xfer) begin
      idx_nxt = idx_r + RUN_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      idx_r <= '0;
    end else begin
      len_r <= len_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes_r <= run.bytes;
    end
  end

`ifndef SYNTHESIS
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= RUN_LEN_W'(MAX_RUN))
    else $error("run length out of range");

  a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (len_r != '0) |-> (RUN_LEN_W'(idx_r) < len_r))
    else $error("run index beyond run length");

  a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (idx_r == '0) && (len_r != '0))
    else $error("new run did not start at its first byte");

  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    (xfer && !last) |=> (idx_r == $past(idx_r) + RUN_IDX_W'(1)))
    else $error("run index did not advance after a transfer");
`endif

endmodule

>>> sv/list_mode_char_escaper.sv
// Top level of the list-mode character escaper.
// Instantiates lmce_in_reg, lmce_escape and lmce_run_buf; uses lmce_pkg.
`timescale 1ns / 1ps

//  Channel  | Ports                                  | Direction | Handshake
//  ---------+----------------------------------------+-----------+------------------
//  input    | in_char_in[7:0], in_list_mode          | in        | in_valid/in_stall
//  result   | out_byte[7:0], out_last_of_run         | out       | out_valid/out_stall
//  config   | cfg_wr_data[6:0] (fold column)         | in        | cfg_wr_en
//
// Each character becomes a run of 1 to 6 bytes, and the result port moves one byte per
// transfer, so an item occupies the output for one transfer per byte of its run.
// The first byte of a run is offered once the character has passed the input register
// and then the run register; the next character is taken in while a run still drains,
// so one-byte runs go at one per cycle when the result side does not stall.
// Reset is synchronous and active low; it sets the fold column to 66 and clears the
// column count, the space flag and both stage valids. A stall on the result side
// holds the current byte and backs up into the input register, then into in_stall.

module list_mode_char_escaper (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_in,
  input  logic       in_list_mode,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last_of_run,
  input  logic       cfg_wr_en,
  input  logic [6:0] cfg_wr_data
);
  import lmce_pkg::*;

  logic       held_vld;
  logic [7:0] held_char;
  logic       held_list;
  logic       load;
  run_t       run;

  // The input register parts the input handshake from the escape logic.
  lmce_in_reg u_in_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_char_in   (in_char_in),
    .in_list_mode (in_list_mode),
    .take         (load),
    .held_vld     (held_vld),
    .held_char    (held_char),
    .held_list    (held_list)
  );

  // The escape stage builds the whole run in one pass and updates the column and
  // space flag at the moment the run is loaded, so state always follows run order.
  lmce_escape u_escape (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .char_in     (held_char),
    .list_mode   (held_list),
    .load        (load),
    .run         (run)
  );

  // The run register loads a new run when it is empty or its last byte leaves.
  lmce_run_buf u_run_buf (
    .clk             (clk),
    .rst_n           (rst_n),
    .run             (run),
    .src_vld         (held_vld),
    .load            (load),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run)
  );

endmodule

>>> verif/list_mode_char_escaper_tb.sv
// Self-checking testbench for the list-mode character escaper.
// Drives characters, checks every output byte against a built-in predictor or a typed-in expected run.
// Depends on lmce_pkg and the list_mode_char_escaper RTL.
`timescale 1ns / 1ps

module list_mode_char_escaper_tb;
  import lmce_pkg::*;

  localparam logic [7:0] CH_DIGIT0 = 8'h30;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_beat_t;

  // One row of the directed script: either a fold-column write or a character.
  // A non-empty want string is the typed-in expected run for that character.
  typedef struct {
    logic       is_cfg;
    logic [6:0] fold;
    logic [7:0] ch;
    logic       lm;
    string      want;
  } stim_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_char_in;
  logic       in_list_mode;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       out_last_of_run;
  logic       cfg_wr_en;
  logic [6:0] cfg_wr_data;

  // Predictor state, mirroring the block's column count, space flag and register.
  logic [6:0] fold_col;
  logic [7:0] col_count;
  bit         after_space;
  logic [7:0] run_bytes[$];

  out_beat_t  pending_bytes[$];
  stim_row_t  script[$];

  int error_count;
  int items_sent;
  int bytes_checked;
  int fold_count;
  int marker_count;
  int octal_count;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_left;

  list_mode_char_escaper i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_char_in      (in_char_in),
    .in_list_mode    (in_list_mode),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    error_count++;
  endtask

  // Appends one byte to the predicted run; the space flag always follows the
  // most recently emitted byte, whichever branch emitted it.
  function void emit_byte(input logic [7:0] b);
    run_bytes.push_back(b);
    after_space = (b == CH_SPACE);
  endfunction

  // Works out the run of bytes one character expands into and advances the
  // column count, leaving the run in run_bytes.
  function automatic void predict_escape(input logic [7:0] ch, input logic lm);
    logic [7:0] tail;
    run_bytes.delete();
    tail = ch;
    if (lm && ch != CH_NL) begin
      // Fold first, then count the character on the fresh line.
      if (col_count >= {1'b0, fold_col}) begin
        col_count = '0;
        emit_byte(CH_BSLASH);
        emit_byte(CH_NL);
        fold_count++;
      end
      if (ch == CH_BS || ch == CH_TAB || ch == CH_BSLASH) begin
        emit_byte(CH_BSLASH);
        tail = (ch == CH_BS) ? CH_LOWER_B : ((ch == CH_TAB) ? CH_LOWER_T : CH_BSLASH);
        col_count = col_count + 8'd2;
      end else if (ch < CH_SPACE || ch >= CH_DEL) begin
        // Octal escape of the unsigned byte value.
        emit_byte(CH_BSLASH);
        emit_byte(CH_DIGIT0 + {6'b0, ch[7:6]});
        emit_byte(CH_DIGIT0 + {5'b0, ch[5:3]});
        tail = CH_DIGIT0 + {5'b0, ch[2:0]};
        col_count = col_count + 8'd4;
        octal_count++;
      end else begin
        col_count = col_count + 8'd1;
      end
    end else if (lm && after_space) begin
      // A newline right after a space gets the visible marker.
      emit_byte(CH_BSLASH);
      emit_byte(CH_LOWER_N);
      marker_count++;
    end
    emit_byte(tail);
    if (ch == CH_NL) begin
      col_count = '0;
    end
  endfunction

  // Offers one character and waits for its transfer. Valid stays high after
  // the transfer, so back-to-back characters need no dead cycle.
  task automatic send_char(input logic [7:0] ch, input logic lm, input string want = "");
    int i;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_char_in   <= ch;
    in_list_mode <= lm;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    predict_escape(ch, lm);
    if (want.len() == 0) begin
      for (i = 0; i < run_bytes.size(); i++) begin
        pending_bytes.push_back('{data: run_bytes[i], last: (i == run_bytes.size() - 1)});
      end
    end else begin
      for (i = 0; i < want.len(); i++) begin
        pending_bytes.push_back('{data: want[i], last: (i == want.len() - 1)});
      end
    end
    items_sent++;
  endtask

  // Every character yields at least one byte, so an empty queue means the
  // block is idle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_bytes.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_fold(input logic [6:0] value);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    fold_col = value;
    cfg_wr_en <= 1'b0;
  endtask

  function automatic void add_char(input logic [7:0] ch, input logic lm, input string want);
    script.push_back('{is_cfg: 1'b0, fold: 7'd0, ch: ch, lm: lm, want: want});
  endfunction

  function automatic void add_cfg(input logic [6:0] value);
    script.push_back('{is_cfg: 1'b1, fold: value, ch: 8'h00, lm: 1'b0, want: ""});
  endfunction

  // Random characters, weighted toward the cases that matter: newlines (some
  // right after a space), escapes, octal bytes and enough printable text for
  // the column to reach the fold point.
  task automatic run_phase(input logic [6:0] fold, input int send_pct, input int recv_pct,
                           input int nl_pct, input int count);
    int         n;
    int         r;
    logic       lm;
    logic [7:0] ch;
    write_fold(fold);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (n = 0; n < count; n++) begin
      r  = $urandom_range(99);
      lm = ($urandom_range(99) < 85);
      if (r < nl_pct) begin
        if ($urandom_range(1) == 1) begin
          send_char(CH_SPACE, lm);
        end
        ch = CH_NL;
      end else if (r < nl_pct + 10) begin
        ch = CH_SPACE;
      end else if (r < nl_pct + 20) begin
        ch = 8'($urandom_range(31));
      end else if (r < nl_pct + 26) begin
        case ($urandom_range(2))
          0: ch = CH_BS;
          1: ch = CH_TAB;
          default: ch = CH_BSLASH;
        endcase
      end else if (r < nl_pct + 34) begin
        ch = 8'($urandom_range(255, 127));
      end else begin
        ch = 8'($urandom_range(126, 33));
      end
      send_char(ch, lm);
    end
  endtask

  // Result side: checks each transfer against the oldest expectation and
  // drives the stall. After the 150th byte it holds off for a long stretch
  // while the sender keeps offering, so the block backs up into in_stall.
  initial begin : result_side
    out_beat_t exp_beat;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        bytes_checked++;
        if (pending_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h", out_byte));
        end else begin
          exp_beat = pending_bytes.pop_front();
          if (out_byte !== exp_beat.data) begin
            report_mismatch($sformatf("byte %0d: out_byte %02h, expected %02h",
                                      bytes_checked, out_byte, exp_beat.data));
          end
          if (out_last_of_run !== exp_beat.last) begin
            report_mismatch($sformatf("byte %0d: out_last_of_run %b, expected %b",
                                      bytes_checked, out_last_of_run, exp_beat.last));
          end
        end
        if (bytes_checked == 150) begin
          hold_left = 300;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  initial begin : stimulus
    int row;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_char_in   <= 8'h00;
    in_list_mode <= 1'b0;
    cfg_wr_en    <= 1'b0;
    cfg_wr_data  <= 7'd0;
    error_count   = 0;
    items_sent    = 0;
    bytes_checked = 0;
    fold_count    = 0;
    marker_count  = 0;
    octal_count   = 0;
    hold_left     = 0;
    send_idle_pct = 8;
    recv_idle_pct = 70;
    fold_col      = FOLD_COLUMN_RESET;
    col_count     = '0;
    after_space   = 1'b0;

    // Directed script. Rows right after reset run at the reset fold column
    // of 66, far from folding. Untyped rows hold raw bytes (NUL and friends)
    // that a string cannot carry; the predictor covers them.
    add_char("A",        1'b1, "A");
    add_char(8'h00,      1'b1, "\\000");
    add_char(8'hFF,      1'b1, "\\377");
    add_char(CH_DEL,     1'b1, "\\177");
    add_char(8'h1F,      1'b1, "\\037");
    add_char(8'h80,      1'b1, "\\200");
    add_char(CH_BS,      1'b1, "\\b");
    add_char(CH_TAB,     1'b1, "\\t");
    add_char(CH_BSLASH,  1'b1, "\\\\");
    add_char(CH_SPACE,   1'b1, " ");
    add_char(CH_NL,      1'b1, "\\n\n");
    add_char(CH_NL,      1'b1, "\n");
    add_char(8'h7E,      1'b1, "~");
    // Pass-through: the space still arms the marker flag, but no marker is
    // written outside list mode, and nothing is escaped.
    add_char(CH_SPACE,   1'b0, " ");
    add_char(CH_NL,      1'b0, "\n");
    add_char(8'h00,      1'b0, "");
    add_char(8'hFF,      1'b0, "");
    add_char(CH_BSLASH,  1'b0, "\\");
    add_char(CH_TAB,     1'b0, "");
    // Fold column of one: folds from the second character on, never before
    // a newline.
    add_cfg(7'd1);
    add_char("a",        1'b1, "a");
    add_char("b",        1'b1, "\\\nb");
    add_char(8'h83,      1'b1, "\\\n\\203");
    add_char(CH_NL,      1'b1, "\n");
    // Fold column of zero: a fold before every non-newline character. The
    // fold's newline does not hide the space from the following newline.
    add_cfg(7'd0);
    add_char("c",        1'b1, "\\\nc");
    add_char(CH_SPACE,   1'b1, "\\\n ");
    add_char(CH_NL,      1'b1, "\\n\n");
    // Largest value that the fold column register can hold.
    add_cfg(7'd127);
    add_char(CH_TAB,     1'b1, "\\t");

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (row = 0; row < script.size(); row++) begin
      if (script[row].is_cfg) begin
        write_fold(script[row].fold);
      end else begin
        send_char(script[row].ch, script[row].lm, script[row].want);
      end
    end

    // Random phases: sender rarely idle with a busy receiver, then the
    // reverse, then full throughput. Fold points go small, large, random.
    run_phase(7'($urandom_range(1, 8)), 8, 70, 6, 135);
    run_phase(7'd120, 70, 8, 1, 135);
    run_phase(7'($urandom_range(0, 127)), 0, 0, 4, 135);

    wait_idle();
    repeat (8) @(posedge clk);

    $display("Sent %0d characters in both modes and checked %0d output bytes.",
             items_sent, bytes_checked);
    $display("Predicted %0d folds, %0d newline markers and %0d octal escapes; %0d mismatches.",
             fold_count, marker_count, octal_count, error_count);
    if (error_count == 0) begin
      $display("list_mode_char_escaper test passed");
    end else begin
      $display("list_mode_char_escaper test failed");
    end
    $finish;
  end

  // Far beyond the slowest legal run, a few thousand bytes at worst stall rates
  // plus the long hold.
  initial begin : watchdog
    #5_000_000;
    $display("Timeout: %0d output bytes still expected.", pending_bytes.size());
    $display("list_mode_char_escaper test failed");
    $finish;
  end

endmodule

>>> filelist.f
sv/lmce_pkg.sv
sv/lmce_in_reg.sv
sv/lmce_escape.sv
sv/lmce_run_buf.sv
sv/list_mode_char_escaper.sv
verif/list_mode_char_escaper_tb.sv
